// File: src/terrain_slope_walkability_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the terrain slope walkability unit
// Concurrent checks with a common clock and report, with or without a reset qualifier.
// ---------------------------------------------------------------------------
`ifndef TERRAIN_SLOPE_WALKABILITY_UNIT_ASSERT_SVH
`define TERRAIN_SLOPE_WALKABILITY_UNIT_ASSERT_SVH

// Check outside reset only.
`define TSWU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: %m");

// Check at every edge, reset included.
`define TSWU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed: %m");

`endif

// File: src/tswu_pkg.sv
// ---------------------------------------------------------------------------
// tswu_pkg
// Shared constants, codes and types of the slope walkability unit.
// ---------------------------------------------------------------------------
package tswu_pkg;

  // Heightfield store size
  localparam int MAX_WIDTH = 256;
  localparam int MAX_DEPTH = 256;
  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int ZW        = $clog2(MAX_DEPTH);
  localparam int AW        = XW + ZW;

  // Field widths
  localparam int HW     = 16;  // height sample, Q8.8
  localparam int POS_W  = 9;   // signed coordinate
  localparam int DIM_W  = 9;   // grid size register
  localparam int LIM_W  = 16;  // slope limit register
  localparam int CFG_DW = 16;  // widest register
  localparam int IDX_W  = 2;

  // Working widths
  localparam int XZW   = (XW > ZW) ? XW : ZW;
  localparam int CW    = ((XZW > POS_W + 1) ? XZW : POS_W + 1) + 1;
  localparam int NW    = 20;             // normal sum, |n| <= 8 * 2^15
  localparam int MAGW  = NW - 1;
  localparam int SQW   = 2 * MAGW;
  localparam int SUMW  = SQW + 1;
  localparam int KW    = 3;              // ny / 256, at most 6
  localparam int LIMPW = 2 * KW + LIM_W;

  // Stream widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // Commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_GRID_DEPTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_SLOPE_LIMIT = 2'd2;

  // Register reset values
  localparam logic [DIM_W-1:0] GRID_WIDTH_RST  = DIM_W'(256);
  localparam logic [DIM_W-1:0] GRID_DEPTH_RST  = DIM_W'(256);
  localparam logic [LIM_W-1:0] SLOPE_LIMIT_RST = LIM_W'(271);

  typedef struct packed {
    logic [DIM_W-1:0] grid_width;
    logic [DIM_W-1:0] grid_depth;
    logic [LIM_W-1:0] slope_limit;
  } cfg_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    logic [HW-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic                 start;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] nz;
    logic [KW-1:0]        k;
  } norm_t;

  typedef struct packed {
    logic done;
    logic walkable;
  } slope_res_t;

  typedef struct packed {
    logic vld;
    logic walkable;
  } result_t;

endpackage

// File: src/tswu_height_ram.sv
// ---------------------------------------------------------------------------
// tswu_height_ram
// Single-port height store, read-first, with a registered read.
// ---------------------------------------------------------------------------
module tswu_height_ram (
  input  logic                    clk_i,
  input  tswu_pkg::ram_req_t      req_i,
  output logic [tswu_pkg::HW-1:0] rdata_o
);
  import tswu_pkg::*;

  logic [HW-1:0] mem [0:(1 << AW) - 1];
  logic [HW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/tswu_slope_cmp.sv
// ---------------------------------------------------------------------------
// tswu_slope_cmp
// Squares the normal with one shared multiplier and compares against the
// slope limit scaled by ny squared.
// ---------------------------------------------------------------------------
module tswu_slope_cmp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tswu_pkg::norm_t            norm_i,
  input  logic [tswu_pkg::LIM_W-1:0] slope_limit_i,
  output tswu_pkg::slope_res_t       res_o
);
  import tswu_pkg::*;

  localparam logic [1:0] PH_X   = 2'd0;
  localparam logic [1:0] PH_Z   = 2'd1;
  localparam logic [1:0] PH_CMP = 2'd2;

  function automatic logic [2*KW-1:0] ksq(input logic [KW-1:0] k);
    return (2*KW)'(k) * (2*KW)'(k);
  endfunction

  logic             busy_q, busy_d;
  logic [1:0]       phase_q, phase_d;
  logic [MAGW-1:0]  ax_q, az_q, op;
  logic [LIMPW-1:0] lim_q;
  logic [SQW-1:0]   sq_q, sq_d;
  logic [SUMW-1:0]  sum_q, sum_d, tot;
  logic             done_q, done_d, walk_q, walk_d;
  logic signed [NW-1:0] anx, anz;

  assign anx = norm_i.nx[NW-1] ? -norm_i.nx : norm_i.nx;
  assign anz = norm_i.nz[NW-1] ? -norm_i.nz : norm_i.nz;

  assign op  = (phase_q == PH_X) ? ax_q : az_q;
  assign tot = sum_q + SUMW'(sq_q);

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    sq_d    = SQW'(op) * SQW'(op);
    sum_d   = sum_q;
    done_d  = 1'b0;
    walk_d  = walk_q;
    if (busy_q) begin
      case (phase_q)
        PH_X: begin
          phase_d = PH_Z;
        end
        PH_Z: begin
          sum_d   = SUMW'(sq_q);
          phase_d = PH_CMP;
        end
        PH_CMP: begin
          done_d = 1'b1;
          walk_d = tot < SUMW'({lim_q, 8'b0});
          busy_d = 1'b0;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end else if (norm_i.start) begin
      busy_d  = 1'b1;
      phase_d = PH_X;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= PH_X;
      done_q  <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && norm_i.start) begin
      ax_q  <= MAGW'(anx);
      az_q  <= MAGW'(anz);
      lim_q <= LIMPW'(ksq(norm_i.k)) * LIMPW'(slope_limit_i);
    end
    sq_q   <= sq_d;
    sum_q  <= sum_d;
    walk_q <= walk_d;
  end

  assign res_o.done     = done_q;
  assign res_o.walkable = walk_q;

endmodule

// File: src/tswu_ctrl.sv
// ---------------------------------------------------------------------------
// tswu_ctrl
// Item sequencer: stores height writes, walks the seven neighbor reads of a
// query through the height store and accumulates the vertex normal.
// ---------------------------------------------------------------------------
module tswu_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_vld_i,
  output logic                              in_rdy_o,
  input  logic                              in_cmd_i,
  input  logic signed [tswu_pkg::POS_W-1:0] in_pos_x_i,
  input  logic signed [tswu_pkg::POS_W-1:0] in_pos_z_i,
  input  logic [tswu_pkg::HW-1:0]           in_height_i,
  input  tswu_pkg::cfg_t                    cfg_i,
  output tswu_pkg::ram_req_t                ram_req_o,
  input  logic [tswu_pkg::HW-1:0]           ram_rdata_i,
  output tswu_pkg::norm_t                   norm_o,
  input  tswu_pkg::slope_res_t              slope_i,
  input  logic                              out_free_i,
  output tswu_pkg::result_t                 res_o
);
  import tswu_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_START  = 3'd4;
  localparam logic [2:0] ST_CALC   = 3'd5;
  localparam logic [2:0] ST_RESULT = 3'd6;

  localparam logic [2:0] LAST_STEP = 3'd6;

  localparam logic signed [CW-1:0] OFF_0 = CW'(0);
  localparam logic signed [CW-1:0] OFF_P = CW'(1);
  localparam logic signed [CW-1:0] OFF_M = CW'(-1);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_W'(2)) r = DIM_W'(2);
    else if (int'(v) > hi) r = DIM_W'(hi);
    return r;
  endfunction

  // Per-sample weights for nx and nz; v holds quad valid bits
  // {lower right, lower left, upper right, upper left}.
  function automatic logic [5:0] coef(input logic [2:0] step, input logic [3:0] v);
    int a, b, c, dq, cx, cz;
    a  = int'(v[0]);
    b  = int'(v[1]);
    c  = int'(v[2]);
    dq = int'(v[3]);
    case (step)
      3'd0: begin cx = b;              cz = a + b;           end
      3'd1: begin cx = -b;             cz = b;               end
      3'd2: begin cx = a + c;          cz = c;               end
      3'd3: begin cx = b + dq - a - c; cz = c + dq - a - b;  end
      3'd4: begin cx = -b - dq;        cz = -b;              end
      3'd5: begin cx = c;              cz = -c;              end
      3'd6: begin cx = -c;             cz = -c - dq;         end
      default: begin cx = 0;           cz = 0;               end
    endcase
    return {3'(cx), 3'(cz)};
  endfunction

  function automatic logic signed [NW-1:0] scale(input logic signed [HW-1:0] h,
                                                 input logic [2:0] c);
    logic signed [NW-1:0] hx, r;
    hx = NW'(h);
    case (c)
      3'b001:  r = hx;
      3'b010:  r = hx <<< 1;
      3'b111:  r = -hx;
      3'b110:  r = -(hx <<< 1);
      default: r = '0;
    endcase
    return r;
  endfunction

  logic [2:0]           state_q, state_d;
  logic signed [POS_W-1:0] px_q, pz_q;
  logic signed [CW-1:0] i_q, j_q;
  logic [3:0]           v_q;
  logic [2:0]           cnt_q, cnt_d, rd_step_q;
  logic                 rd_vld_q;
  logic signed [NW-1:0] nx_q, nx_d, nz_q, nz_d;
  logic                 walk_q, walk_d;

  logic [DIM_W-1:0]     w, d;
  logic signed [CW-1:0] ws, ds, i_c, j_c, dxs, dzs, xs, zs, pxw, pzw;
  logic                 on_grid, in_acc, wr_ok;
  logic [3:0]           v_c;
  logic [5:0]           cf;

  assign w  = clamp_dim(cfg_i.grid_width, MAX_WIDTH);
  assign d  = clamp_dim(cfg_i.grid_depth, MAX_DEPTH);
  assign ws = $signed(CW'(w));
  assign ds = $signed(CW'(d));

  // Shift the world position onto the grid
  assign i_c = CW'(px_q) + $signed(CW'(w[DIM_W-1:1]));
  assign j_c = CW'(pz_q) + $signed(CW'(d[DIM_W-1:1]));
  assign on_grid = (i_c >= 0) && (j_c >= 0) && (i_c < ws) && (j_c < ds);

  assign v_c[0] = (i_c > 0) && (j_c > 0);
  assign v_c[1] = (i_c < ws - OFF_P) && (j_c > 0);
  assign v_c[2] = (i_c > 0) && (j_c < ds - OFF_P);
  assign v_c[3] = (i_c < ws - OFF_P) && (j_c < ds - OFF_P);

  assign in_rdy_o = (state_q == ST_IDLE);
  assign in_acc   = in_vld_i && in_rdy_o;

  assign pxw   = CW'(in_pos_x_i);
  assign pzw   = CW'(in_pos_z_i);
  assign wr_ok = (in_pos_x_i >= 0) && (in_pos_z_i >= 0) &&
                 (int'(in_pos_x_i) < MAX_WIDTH) && (int'(in_pos_z_i) < MAX_DEPTH);

  always_comb begin
    case (cnt_q)
      3'd0:    begin dxs = OFF_0; dzs = OFF_M; end
      3'd1:    begin dxs = OFF_P; dzs = OFF_M; end
      3'd2:    begin dxs = OFF_M; dzs = OFF_0; end
      3'd3:    begin dxs = OFF_0; dzs = OFF_0; end
      3'd4:    begin dxs = OFF_P; dzs = OFF_0; end
      3'd5:    begin dxs = OFF_M; dzs = OFF_P; end
      3'd6:    begin dxs = OFF_0; dzs = OFF_P; end
      default: begin dxs = OFF_0; dzs = OFF_0; end
    endcase
  end

  // Neighbors off the store only ever carry zero weight
  assign xs = i_q + dxs;
  assign zs = j_q + dzs;

  always_comb begin
    ram_req_o.wdata = in_height_i;
    if (state_q == ST_IDLE) begin
      ram_req_o.we   = in_acc && (in_cmd_i == CMD_WRITE) && wr_ok;
      ram_req_o.addr = {pzw[ZW-1:0], pxw[XW-1:0]};
    end else begin
      ram_req_o.we   = 1'b0;
      ram_req_o.addr = {zs[ZW-1:0], xs[XW-1:0]};
    end
  end

  assign cf = coef(rd_step_q, v_q);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    nx_d    = nx_q;
    nz_d    = nz_q;
    walk_d  = walk_q;
    if (rd_vld_q) begin
      nx_d = nx_q + scale(ram_rdata_i, cf[5:3]);
      nz_d = nz_q + scale(ram_rdata_i, cf[2:0]);
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_cmd_i == CMD_QUERY)) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        nx_d  = '0;
        nz_d  = '0;
        cnt_d = '0;
        if (on_grid) begin
          state_d = ST_READ;
        end else begin
          walk_d  = 1'b0;
          state_d = ST_RESULT;
        end
      end
      ST_READ: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == LAST_STEP) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_START;
      end
      ST_START: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        if (slope_i.done) begin
          walk_d  = slope_i.walkable;
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q <= in_pos_x_i;
      pz_q <= in_pos_z_i;
    end
    if (state_q == ST_SETUP) begin
      i_q <= i_c;
      j_q <= j_c;
      v_q <= v_c;
    end
    cnt_q     <= cnt_d;
    rd_step_q <= cnt_q;
    nx_q      <= nx_d;
    nz_q      <= nz_d;
    walk_q    <= walk_d;
  end

  assign norm_o.start = (state_q == ST_START);
  assign norm_o.nx    = nx_q;
  assign norm_o.nz    = nz_q;
  assign norm_o.k     = KW'({2'b0, v_q[0]}) + KW'({1'b0, v_q[1], 1'b0}) +
                        KW'({1'b0, v_q[2], 1'b0}) + KW'({2'b0, v_q[3]});

  assign res_o.vld      = (state_q == ST_RESULT) && out_free_i;
  assign res_o.walkable = walk_q;

endmodule

// File: src/terrain_slope_walkability_unit.sv
// ---------------------------------------------------------------------------
// terrain_slope_walkability_unit
// Heightfield store with slope walkability queries on grid vertices.
//
//   channel  | direction | fields (low bit first)
//   s_axis   | in        | tdata: pos_x[8:0], pos_z[17:9], height[33:18]; tuser: cmd
//   m_axis   | out       | tdata: walkable[0]
//   cfg      | in        | cfg_idx_i: grid_width, grid_depth, slope_limit
//
// A height write is stored as it is accepted. An on-grid query makes seven reads
// through the single port of the height store, then two squarings on one
// multiplier and the compare; an off-grid query skips both. No new item is
// accepted until a query's result has moved to the output register. A result
// waits there while the next item is accepted; a query that finishes while that
// register is still full holds until it drains. Reset clears control and
// configuration but not the height store, which is valid only once written.
// ---------------------------------------------------------------------------
`include "terrain_slope_walkability_unit_assert.svh"

module terrain_slope_walkability_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [tswu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // pos_x, pos_z, height
  input  logic                                s_axis_tuser,   // cmd
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [tswu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // walkable
  input  logic                                cfg_we_i,
  input  logic [tswu_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [tswu_pkg::CFG_DW-1:0]         cfg_data_i
);
  import tswu_pkg::*;

  cfg_t                    cfg_q;
  ram_req_t                ram_req;
  logic [HW-1:0]           ram_rdata;
  norm_t                   norm;
  slope_res_t              slope_res;
  result_t                 res;
  logic                    out_vld_q, out_walk_q, out_free;
  logic signed [POS_W-1:0] pos_x, pos_z;
  logic [HW-1:0]           height;

  assign pos_x  = s_axis_tdata[POS_W-1:0];
  assign pos_z  = s_axis_tdata[2*POS_W-1:POS_W];
  assign height = s_axis_tdata[2*POS_W+HW-1:2*POS_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width  <= GRID_WIDTH_RST;
      cfg_q.grid_depth  <= GRID_DEPTH_RST;
      cfg_q.slope_limit <= SLOPE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_WIDTH:  cfg_q.grid_width  <= cfg_data_i[DIM_W-1:0];
        REG_GRID_DEPTH:  cfg_q.grid_depth  <= cfg_data_i[DIM_W-1:0];
        REG_SLOPE_LIMIT: cfg_q.slope_limit <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  tswu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_vld_i    (s_axis_tvalid),
    .in_rdy_o    (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_pos_x_i  (pos_x),
    .in_pos_z_i  (pos_z),
    .in_height_i (height),
    .cfg_i       (cfg_q),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .norm_o      (norm),
    .slope_i     (slope_res),
    .out_free_i  (out_free),
    .res_o       (res)
  );

  tswu_height_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  tswu_slope_cmp u_cmp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .norm_i        (norm),
    .slope_limit_i (cfg_q.slope_limit),
    .res_o         (slope_res)
  );

  // Output register: load a result when empty or draining this cycle
  assign out_free = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res.vld) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.vld) begin
      out_walk_q <= res.walkable;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_walk_q};

  `TSWU_ASSERT(a_res_slot_free, clk_i, rst_ni, res.vld |-> (!out_vld_q || m_axis_tready))
  `TSWU_ASSERT(a_query_blocks_input, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_QUERY) |=> !s_axis_tready)
  `TSWU_ASSERT(a_res_only_when_busy, clk_i, rst_ni, res.vld |-> !s_axis_tready)
  `TSWU_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !m_axis_tvalid)

endmodule
